>>> sv/lkv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LRU key-value cache.
// No dependencies. Imported by the controller, datapath and top level.
package lkv_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic capture;
		logic commit;
	} lkv_cmd_t;

	typedef struct packed {
		logic get_pending;
		logic out_blocked;
	} lkv_sts_t;

endpackage

>>> sv/lkv_ctrl.sv
`timescale 1ns / 1ps
// Controller of the LRU key-value cache: two-state sequencer (lookup, update).
// Depends on lkv_pkg.
module lkv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lkv_pkg::lkv_sts_t sts,
	output lkv_pkg::lkv_cmd_t cmd
);
	import lkv_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPDT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDT;
				end
			end
			ST_UPDT: begin
				// a get waits while the previous result is still held
				if (!(sts.get_pending && sts.out_blocked)) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/lkv_dp.sv
`timescale 1ns / 1ps
// Datapath of the LRU key-value cache: entry shift array, parallel key compare,
// fill count, capacity register and result register. Depends on lkv_pkg.
module lkv_dp #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lkv_pkg::lkv_cmd_t        cmd,
	output lkv_pkg::lkv_sts_t        sts,
	input  logic                     cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data,
	input  logic                     op,
	input  logic [KEY_BITS-1:0]      lookup_key,
	input  logic [VALUE_BITS-1:0]    store_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [VALUE_BITS-1:0]    read_value
);
	import lkv_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CW-1:0] r;
		if (c == '0) begin
			r = CW'(1);
		end else if (32'(c) > MAX_ENTRIES) begin
			r = CW'(MAX_ENTRIES);
		end else begin
			r = CW'(c);
		end
		return r;
	endfunction

	logic [KEY_BITS-1:0]   keys_q [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] vals_q [MAX_ENTRIES];
	logic [CW-1:0]         used_q;
	logic [CAP_W-1:0]      cap_q;
	logic [CW-1:0]         cap_eff;
	logic [CW-1:0]         cfg_eff;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] sh_d;
	logic                   any_hit;
	logic [VALUE_BITS-1:0]  hit_val;
	logic [CW-1:0]          target;

	logic                   op_s1;
	logic                   hit_s1;
	logic                   grow_s1;
	logic [MAX_ENTRIES-1:0] sh_s1;
	logic [KEY_BITS-1:0]    key_s1;
	logic [VALUE_BITS-1:0]  val_s1;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [VALUE_BITS-1:0]  rdata_q;
	logic [VALUE_BITS-1:0]  front_val;

	assign cap_eff = eff_cap(cap_q);
	assign cfg_eff = eff_cap(cfg_wr_data);

	always_comb begin
		hit_val = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = (CW'(i) < used_q) && (keys_q[i] == lookup_key);
			if (match[i]) begin
				hit_val = hit_val | vals_q[i];
			end
		end
		any_hit = |match;
		target  = (used_q < cap_eff) ? used_q : cap_eff - CW'(1);
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (any_hit) begin
				sh_d[i] = |(match >> i);
			end else if (op == OP_SET) begin
				sh_d[i] = (CW'(i) <= target);
			end else begin
				sh_d[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= op;
			hit_s1  <= any_hit;
			grow_s1 <= (op == OP_SET) && !any_hit && (used_q < cap_eff);
			sh_s1   <= sh_d;
			key_s1  <= lookup_key;
			val_s1  <= (op == OP_SET) ? store_value : hit_val;
		end
	end

	assign front_val = val_s1;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (sh_s1[0]) begin
				keys_q[0] <= key_s1;
				vals_q[0] <= front_val;
			end
			for (int i = 1; i < MAX_ENTRIES; i++) begin
				if (sh_s1[i]) begin
					keys_q[i] <= keys_q[i-1];
					vals_q[i] <= vals_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cap_q  <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
			if (used_q > cfg_eff) begin
				used_q <= cfg_eff;
			end
		end else if (cmd.commit && grow_s1) begin
			used_q <= used_q + CW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && (op_s1 == OP_GET)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (op_s1 == OP_GET)) begin
			hit_q   <= hit_s1;
			rdata_q <= hit_s1 ? val_s1 : '0;
		end
	end

	assign sts.get_pending = (op_s1 == OP_GET);
	assign sts.out_blocked = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;

endmodule

>>> sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkv_pkg, lkv_ctrl and lkv_dp.
//
// Holds up to MAX_ENTRIES key/value pairs in recency order, most recent first.
// Each item passes a lookup step, which compares the key with all entries in
// parallel and registers the hit position, then an update step, which shifts the
// entry array one place toward the back and writes the front on a hit or a set.
// A get returns one result (hit flag and value, value zero on a miss); a set
// returns none. A get waits in its update step while the previous result is
// still held by out_stall. capacity_in_use (cfg_wr_data) limits the fill; 0 acts
// as 1, values above MAX_ENTRIES act as MAX_ENTRIES, and lowering it drops the
// oldest pairs. Write it only while the block is idle.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 16,
	parameter int VALUE_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic [KEY_BITS-1:0]       lookup_key,
	input  logic [VALUE_BITS-1:0]     store_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic [VALUE_BITS-1:0]     read_value
);
	import lkv_pkg::*;

	lkv_cmd_t cmd;
	lkv_sts_t sts;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lkv_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

endmodule

>>> sim/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// Testbench for lru_key_value_cache: directed lookups, then random get/set traffic over
// several capacity settings, checked against a recency-ordered cache predictor.
// Depends on lkv_pkg and lru_key_value_cache.
module lru_key_value_cache_tb;
	import lkv_pkg::*;

	localparam int DEPTH = 16;
	localparam int NUM_PHASES = 11;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic        hit;
		logic [15:0] value;
	} lookup_t;

	class cache_scoreboard;
		logic [15:0] keys [DEPTH];
		logic [15:0] vals [DEPTH];
		int unsigned used;
		int unsigned cap_eff;
		int unsigned mismatches;
		lookup_t     lookup_q [$];

		function new();
			used = 0;
			cap_eff = DEPTH;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [4:0] c);
			if (c == 0)
				cap_eff = 1;
			else if (c > DEPTH)
				cap_eff = DEPTH;
			else
				cap_eff = c;
			if (used > cap_eff)
				used = cap_eff;
		endfunction

		function void move_front(int unsigned pos, logic [15:0] k, logic [15:0] v);
			int unsigned i;
			for (i = pos; i > 0; i--) begin
				keys[i] = keys[i-1];
				vals[i] = vals[i-1];
			end
			keys[0] = k;
			vals[0] = v;
		endfunction

		function void note_transfer(logic o, logic [15:0] k, logic [15:0] v);
			int unsigned pos;
			int unsigned i;
			lookup_t r;
			pos = used;
			for (i = 0; i < used; i++) begin
				if (keys[i] == k) begin
					pos = i;
					break;
				end
			end
			if (o == OP_GET) begin
				r.hit = (pos < used);
				r.value = r.hit ? vals[pos] : 16'd0;
				if (r.hit)
					move_front(pos, k, r.value);
				lookup_q.push_back(r);
			end else if (pos < used) begin
				move_front(pos, k, v);
			end else if (used < cap_eff) begin
				move_front(used, k, v);
				used++;
			end else begin
				move_front(cap_eff - 1, k, v);
			end
		endfunction

		function void check_lookup(logic h, logic [15:0] v);
			lookup_t e;
			if (lookup_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0d value=%h", h, v);
				return;
			end
			e = lookup_q.pop_front();
			if (h !== e.hit || v !== e.value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected hit=%0d value=%h, got hit=%0d value=%h",
						e.hit, e.value, h, v);
			end
		endfunction

		function int pending();
			return lookup_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [15:0] lookup_key;
	logic [15:0] store_value;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [15:0] read_value;

	cache_scoreboard sb;
	bit              long_hold;
	int unsigned     cycle_count;

	lru_key_value_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_lookup(hit, read_value);
	end

	// receiver: stall pattern changes per stretch; long hold-off on request
	initial begin
		int unsigned mode;
		int unsigned len;
		int unsigned hold_cnt;
		int unsigned n;
		logic        s;
		out_stall = 1'b0;
		hold_cnt = 0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(20, 80);
			for (n = 0; n < len; n++) begin
				@(negedge clk);
				if (long_hold && hold_cnt == 0) begin
					hold_cnt = LONG_HOLD_CYCLES;
					long_hold = 0;
				end
				case (mode)
					0: s = 1'b0;
					1: s = ($urandom_range(0, 3) == 0);
					2: s = ($urandom_range(0, 3) != 0);
					default: s = (n % 3 != 0);
				endcase
				if (hold_cnt > 0) begin
					s = 1'b1;
					hold_cnt--;
				end
				out_stall <= s;
			end
		end
	end

	task automatic send_request(input logic o, input logic [15:0] k, input logic [15:0] v);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		lookup_key <= k;
		store_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_transfer(o, k, v);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] c);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(c);
	endtask

	initial begin
		logic [4:0]  phase_caps [NUM_PHASES];
		logic [15:0] key_pool [DEPTH + 4];
		int unsigned pool_n;
		int unsigned burst_left;
		int          ph;
		int          n;
		int          i;
		logic        o;
		logic [15:0] k;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		op = OP_GET;
		lookup_key = '0;
		store_value = '0;
		long_hold = 0;
		sb = new();
		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd17, 5'd7, 5'd16, 5'd5};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty miss, extremes, update, miss on a non-empty cache
		send_request(OP_GET, 16'h0000, 16'h0000);
		send_request(OP_SET, 16'h0000, 16'hFFFF);
		send_request(OP_SET, 16'hFFFF, 16'h0000);
		send_request(OP_GET, 16'h0000, 16'h0000);
		send_request(OP_GET, 16'hFFFF, 16'hFFFF);
		send_request(OP_SET, 16'h0000, 16'h1234);
		send_request(OP_GET, 16'h0000, 16'h0000);
		send_request(OP_GET, 16'h5555, 16'h0000);
		send_request(OP_SET, 16'hAAAA, 16'hAAAA);
		send_request(OP_GET, 16'hAAAA, 16'h5555);
		// capacity 0 acts as 1 and trims the fill
		write_capacity(5'd0);
		send_request(OP_GET, 16'hAAAA, 16'h0000);
		send_request(OP_GET, 16'h0000, 16'h0000);
		send_request(OP_SET, 16'h1111, 16'h0001);
		send_request(OP_GET, 16'hAAAA, 16'h0000);
		send_request(OP_GET, 16'h1111, 16'h0000);
		// capacity above the array size
		write_capacity(5'd31);
		send_request(OP_SET, 16'h2222, 16'h0002);
		send_request(OP_GET, 16'h1111, 16'h0000);
		send_request(OP_GET, 16'h2222, 16'h0000);
		// eviction of the least recently used pair
		write_capacity(5'd2);
		send_request(OP_SET, 16'h3333, 16'h0003);
		send_request(OP_GET, 16'h2222, 16'h0000);
		send_request(OP_GET, 16'h1111, 16'h0000);
		send_request(OP_GET, 16'h3333, 16'h0000);

		burst_left = 0;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			write_capacity(phase_caps[ph]);
			pool_n = sb.cap_eff + $urandom_range(1, 4);
			for (i = 0; i < pool_n; i++)
				key_pool[i] = 16'($urandom);
			if (ph == 5)
				long_hold = 1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 2 && n == 30)
					drain_results();
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					if ($urandom_range(0, 9) < 7)
						pause_sender($urandom_range(1, 8));
				end
				burst_left--;
				o = $urandom_range(0, 1) ? OP_SET : OP_GET;
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_n - 1)];
				else
					k = 16'($urandom);
				send_request(o, k, 16'($urandom));
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/lkv_pkg.sv
sv/lkv_ctrl.sv
sv/lkv_dp.sv
sv/lru_key_value_cache.sv
sim/lru_key_value_cache_tb.sv
